// ===== rtl/otq_pkg.sv =====
// otq_pkg: shared constants, codes and control structs for the ordered timer queue.
// No dependencies; used by the interfaces, the controller, the datapath and the top level.
package otq_pkg;

  localparam int CAPACITY = 32;
  localparam int SLOT_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int TIME_W   = 48;
  localparam int PERIOD_W = 32;
  localparam int HANDLE_W = 5;
  localparam int KIND_W   = 2;

  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(CAPACITY - 1);

  localparam logic CMD_ADD    = 1'b0;
  localparam logic CMD_EXPIRE = 1'b1;

  typedef enum logic [KIND_W-1:0] {
    KIND_ADD_OK    = 2'd0,
    KIND_ADD_FULL  = 2'd1,
    KIND_FIRED     = 2'd2,
    KIND_PASS_DONE = 2'd3
  } res_kind_t;

  // what a table sweep computes
  typedef enum logic [1:0] {
    SCAN_MIN  = 2'd0,  // earliest busy deadline and lowest free slot
    SCAN_DUE  = 2'd1,  // mark busy timers due at the current time
    SCAN_PICK = 2'd2   // earliest due timer, lowest slot on ties
  } scan_mode_t;

  typedef struct packed {
    logic       latch_in;
    logic       scan_start;
    scan_mode_t scan_mode;
    logic       add_commit;
    logic       fire_commit;
    logic       load_res;
    res_kind_t  res_kind;
  } ctrl_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic found;
    logic free_found;
  } dp_stat_t;

endpackage

// ===== rtl/otq_in_if.sv =====
// otq_in_if: command channel of the timer queue (valid/ready plus command payload).
// Depends on otq_pkg for field widths.
interface otq_in_if import otq_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                cmd;
  logic [TIME_W-1:0]   time_value;
  logic [PERIOD_W-1:0] interval_us;

  modport source (output valid, cmd, time_value, interval_us, input ready);
  modport sink   (input valid, cmd, time_value, interval_us, output ready);
endinterface

// ===== rtl/otq_out_if.sv =====
// otq_out_if: result channel of the timer queue (valid/ready plus result payload).
// Depends on otq_pkg for field widths.
interface otq_out_if import otq_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [KIND_W-1:0]   kind;
  logic [HANDLE_W-1:0] handle;
  logic                earliest_changed;
  logic                deadline_valid;
  logic [TIME_W-1:0]   next_deadline;
  logic                last;

  modport source (output valid, kind, handle, earliest_changed, deadline_valid,
                  next_deadline, last, input ready);
  modport sink   (input valid, kind, handle, earliest_changed, deadline_valid,
                  next_deadline, last, output ready);
endinterface

// ===== rtl/ordered_timer_queue_unit.sv =====
// ordered_timer_queue_unit: top level of the deadline-ordered timer queue.
// Depends on otq_pkg, otq_in_if, otq_out_if, otq_ctrl and otq_dp.
//
//   channel   | dir | transfer payload
//   ----------+-----+-----------------------------------------------------------
//   in_chan   | in  | cmd, time_value, interval_us (add deadline / expire time)
//   out_chan  | out | kind, handle, earliest_changed, deadline_valid,
//             |     | next_deadline, last
//
// Every command sweeps the timer tables one slot per cycle through a
// registered read port. Add: one sweep for lowest free slot and earliest
// deadline, then the commit. Expire with F fired timers: one sweep marks due
// timers, one sweep per fired timer picks the earliest (deadline, slot), one
// more pick sweep finds none left, one last sweep finds the next deadline.
// Reset (rst_n low, synchronous) clears the slot and due flags and the
// controller; table contents are not cleared and are read only for busy slots.
// A new command is taken only once the previous one has queued its last result;
// that last result may still sit in the output register. A stalled out_chan
// holds the sequencer before each further result.
module ordered_timer_queue_unit import otq_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  otq_in_if.sink    in_chan,
  otq_out_if.source out_chan
);

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  otq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_cmd    (in_chan.cmd),
    .in_ready  (in_chan.ready),
    .out_ready (out_chan.ready),
    .out_valid (out_chan.valid),
    .stat      (stat),
    .cmd       (cmd)
  );

  otq_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .in_time_value  (in_chan.time_value),
    .in_interval_us (in_chan.interval_us),
    .res_kind       (out_chan.kind),
    .res_handle     (out_chan.handle),
    .res_changed    (out_chan.earliest_changed),
    .res_dvalid     (out_chan.deadline_valid),
    .res_next       (out_chan.next_deadline),
    .res_last       (out_chan.last)
  );

endmodule

// ===== rtl/otq_ctrl.sv =====
// otq_ctrl: sequencer for add and expire commands; drives the datapath by command struct.
// Depends on otq_pkg.
module otq_ctrl import otq_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_cmd,
  output logic      in_ready,
  input  logic      out_ready,
  output logic      out_valid,
  input  dp_stat_t  stat,
  output ctrl_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ADD_SCAN,
    S_ADD_DONE,
    S_DUE_SCAN,
    S_PICK_SCAN,
    S_FIRE,
    S_FINAL_SCAN,
    S_FINAL_OUT
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r;
  logic   out_free;

  // result register can take a new result if empty or draining this cycle
  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign in_ready  = (state_r == S_IDLE);

  always_comb begin
    state_nxt       = state_r;
    cmd             = '0;
    cmd.scan_mode   = SCAN_MIN;
    cmd.res_kind    = KIND_PASS_DONE;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch_in   = 1'b1;
          cmd.scan_start = 1'b1;
          if (in_cmd == CMD_EXPIRE) begin
            cmd.scan_mode = SCAN_DUE;
            state_nxt     = S_DUE_SCAN;
          end else begin
            cmd.scan_mode = SCAN_MIN;
            state_nxt     = S_ADD_SCAN;
          end
        end
      end
      S_ADD_SCAN: begin
        if (stat.scan_done) begin
          state_nxt = S_ADD_DONE;
        end
      end
      S_ADD_DONE: begin
        if (out_free) begin
          cmd.load_res   = 1'b1;
          cmd.add_commit = stat.free_found;
          cmd.res_kind   = stat.free_found ? KIND_ADD_OK : KIND_ADD_FULL;
          state_nxt      = S_IDLE;
        end
      end
      S_DUE_SCAN: begin
        if (stat.scan_done) begin
          cmd.scan_start = 1'b1;
          cmd.scan_mode  = SCAN_PICK;
          state_nxt      = S_PICK_SCAN;
        end
      end
      S_PICK_SCAN: begin
        if (stat.scan_done) begin
          if (stat.found) begin
            state_nxt = S_FIRE;
          end else begin
            cmd.scan_start = 1'b1;
            cmd.scan_mode  = SCAN_MIN;
            state_nxt      = S_FINAL_SCAN;
          end
        end
      end
      S_FIRE: begin
        if (out_free) begin
          cmd.load_res    = 1'b1;
          cmd.res_kind    = KIND_FIRED;
          cmd.fire_commit = 1'b1;
          cmd.scan_start  = 1'b1;
          cmd.scan_mode   = SCAN_PICK;
          state_nxt       = S_PICK_SCAN;
        end
      end
      S_FINAL_SCAN: begin
        if (stat.scan_done) begin
          state_nxt = S_FINAL_OUT;
        end
      end
      S_FINAL_OUT: begin
        if (out_free) begin
          cmd.load_res = 1'b1;
          cmd.res_kind = KIND_PASS_DONE;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cmd.load_res) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/otq_dp.sv =====
// otq_dp: timer tables, sweep pipeline, slot flags and result register.
// Depends on otq_pkg; commanded by otq_ctrl.
module otq_dp import otq_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  ctrl_cmd_t           cmd,
  output dp_stat_t            stat,
  input  logic [TIME_W-1:0]   in_time_value,
  input  logic [PERIOD_W-1:0] in_interval_us,
  output logic [KIND_W-1:0]   res_kind,
  output logic [HANDLE_W-1:0] res_handle,
  output logic                res_changed,
  output logic                res_dvalid,
  output logic [TIME_W-1:0]   res_next,
  output logic                res_last
);

  // tables
  logic [TIME_W-1:0]   deadline_mem_r [CAPACITY];
  logic [PERIOD_W-1:0] period_mem_r   [CAPACITY];
  logic [CAPACITY-1:0] busy_r;
  logic [CAPACITY-1:0] due_r;

  // latched command operands
  logic [TIME_W-1:0]   t_r;
  logic [PERIOD_W-1:0] ival_r;

  // sweep: read stage, compare stage, done flag
  scan_mode_t          mode_r;
  logic                rd_act_r;
  logic [SLOT_W-1:0]   rd_idx_r;
  logic                cmp_vld_r;
  logic [SLOT_W-1:0]   cmp_idx_r;
  logic [TIME_W-1:0]   dl_q_r;
  logic [PERIOD_W-1:0] pd_q_r;
  logic                done_r;

  // sweep results
  logic                found_r;
  logic [TIME_W-1:0]   best_dl_r;
  logic [SLOT_W-1:0]   best_idx_r;
  logic [PERIOD_W-1:0] best_pd_r;
  logic                free_found_r;
  logic [SLOT_W-1:0]   free_idx_r;

  // result register
  res_kind_t           res_kind_r;
  logic [HANDLE_W-1:0] res_handle_r;
  logic                res_changed_r;
  logic                res_dvalid_r;
  logic [TIME_W-1:0]   res_next_r;
  logic                res_last_r;

  logic [TIME_W:0]     reload_sum;
  logic [TIME_W-1:0]   reload_dl;
  logic                new_earliest;
  logic                wr_en;
  logic [SLOT_W-1:0]   wr_idx;
  logic [TIME_W-1:0]   wr_dl;
  logic                cmp_busy;
  logic                cmp_due;

  assign reload_sum   = {1'b0, t_r} + (TIME_W+1)'(best_pd_r);
  assign reload_dl    = reload_sum[TIME_W] ? {TIME_W{1'b1}} : reload_sum[TIME_W-1:0];
  assign new_earliest = !found_r || (t_r < best_dl_r);

  assign wr_en  = cmd.add_commit || (cmd.fire_commit && (best_pd_r != '0));
  assign wr_idx = cmd.add_commit ? free_idx_r : best_idx_r;
  assign wr_dl  = cmd.add_commit ? t_r : reload_dl;

  assign cmp_busy = busy_r[cmp_idx_r];
  assign cmp_due  = due_r[cmp_idx_r];

  assign stat.scan_done  = done_r;
  assign stat.found      = found_r;
  assign stat.free_found = free_found_r;

  assign res_kind    = res_kind_r;
  assign res_handle  = res_handle_r;
  assign res_changed = res_changed_r;
  assign res_dvalid  = res_dvalid_r;
  assign res_next    = res_next_r;
  assign res_last    = res_last_r;

  // tables: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      deadline_mem_r[wr_idx] <= wr_dl;
    end
    if (cmd.add_commit) begin
      period_mem_r[free_idx_r] <= ival_r;
    end
    dl_q_r <= deadline_mem_r[rd_idx_r];
    pd_q_r <= period_mem_r[rd_idx_r];
  end

  // operands, sweep results and result payload
  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      t_r    <= in_time_value;
      ival_r <= in_interval_us;
    end
    cmp_idx_r <= rd_idx_r;
    if (cmd.scan_start) begin
      mode_r <= cmd.scan_mode;
    end
    if (cmp_vld_r) begin
      case (mode_r)
        SCAN_MIN: begin
          if (cmp_busy && (!found_r || dl_q_r < best_dl_r)) begin
            best_dl_r <= dl_q_r;
          end
          if (!cmp_busy && !free_found_r) begin
            free_idx_r <= cmp_idx_r;
          end
        end
        SCAN_PICK: begin
          if (cmp_due && (!found_r || dl_q_r < best_dl_r)) begin
            best_dl_r  <= dl_q_r;
            best_idx_r <= cmp_idx_r;
            best_pd_r  <= pd_q_r;
          end
        end
        default: begin
        end
      endcase
    end
    if (cmd.load_res) begin
      res_kind_r    <= cmd.res_kind;
      res_handle_r  <= '0;
      res_changed_r <= 1'b0;
      res_dvalid_r  <= found_r;
      res_next_r    <= found_r ? best_dl_r : '0;
      res_last_r    <= 1'b1;
      case (cmd.res_kind)
        KIND_ADD_OK: begin
          res_handle_r  <= HANDLE_W'(free_idx_r);
          res_changed_r <= new_earliest;
          res_dvalid_r  <= 1'b1;
          res_next_r    <= new_earliest ? t_r : best_dl_r;
        end
        KIND_FIRED: begin
          res_handle_r <= HANDLE_W'(best_idx_r);
          res_dvalid_r <= 1'b0;
          res_next_r   <= '0;
          res_last_r   <= 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  // control: sweep sequencing, found flags, slot flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_act_r     <= 1'b0;
      rd_idx_r     <= '0;
      cmp_vld_r    <= 1'b0;
      done_r       <= 1'b0;
      found_r      <= 1'b0;
      free_found_r <= 1'b0;
      busy_r       <= '0;
      due_r        <= '0;
    end else begin
      cmp_vld_r <= rd_act_r;
      done_r    <= cmp_vld_r && (cmp_idx_r == LAST_SLOT);
      if (cmd.scan_start) begin
        rd_act_r     <= 1'b1;
        rd_idx_r     <= '0;
        found_r      <= 1'b0;
        free_found_r <= 1'b0;
      end else if (rd_act_r) begin
        if (rd_idx_r == LAST_SLOT) begin
          rd_act_r <= 1'b0;
        end else begin
          rd_idx_r <= rd_idx_r + SLOT_W'(1);
        end
      end
      if (cmp_vld_r) begin
        case (mode_r)
          SCAN_MIN: begin
            if (cmp_busy) begin
              found_r <= 1'b1;
            end else begin
              free_found_r <= 1'b1;
            end
          end
          SCAN_DUE: begin
            due_r[cmp_idx_r] <= cmp_busy && (dl_q_r <= t_r);
          end
          SCAN_PICK: begin
            if (cmp_due) begin
              found_r <= 1'b1;
            end
          end
          default: begin
          end
        endcase
      end
      if (cmd.add_commit) begin
        busy_r[free_idx_r] <= 1'b1;
      end
      if (cmd.fire_commit) begin
        due_r[best_idx_r] <= 1'b0;
        if (best_pd_r == '0) begin
          busy_r[best_idx_r] <= 1'b0;
        end
      end
    end
  end

endmodule

// ===== verif/tb_ordered_timer_queue_unit.sv =====
// tb_ordered_timer_queue_unit: self-checking bench for the deadline-ordered timer queue.
// Depends on otq_pkg, otq_in_if, otq_out_if and ordered_timer_queue_unit; it keeps its
// own copy of the timer table, predicts every result and checks each out_chan transfer.
module tb_ordered_timer_queue_unit import otq_pkg::*; ;

  timeunit 1ns;
  timeprecision 1ps;

  // Longest stretch with no transfer on either channel before the run is abandoned.
  localparam int STALL_LIMIT = 2000;
  // Quiet time after the last result; a stray result would show up here.
  localparam int TAIL_CYCLES = 4 * (CAPACITY + 3);
  localparam logic [TIME_W-1:0] TIME_TOP = {TIME_W{1'b1}};
  localparam logic [PERIOD_W-1:0] PERIOD_TOP = {PERIOD_W{1'b1}};
  localparam int MAX_PRINTS = 40;

  typedef struct packed {
    logic                cmd;
    logic [TIME_W-1:0]   time_value;
    logic [PERIOD_W-1:0] interval_us;
  } timer_cmd_t;

  typedef struct packed {
    res_kind_t           kind;
    logic [HANDLE_W-1:0] handle;
    logic                earliest_changed;
    logic                deadline_valid;
    logic [TIME_W-1:0]   next_deadline;
    logic                last;
  } timer_result_t;

  logic clk;
  logic rst_n;

  otq_in_if  in_chan ();
  otq_out_if out_chan ();

  ordered_timer_queue_unit uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  // Commands not yet handed to the driver, and results still owed by the block.
  timer_cmd_t    cmd_backlog[$];
  timer_result_t awaited_results[$];

  // Shadow timer table.
  logic [TIME_W-1:0]   tbl_deadline[CAPACITY];
  logic [PERIOD_W-1:0] tbl_period[CAPACITY];
  logic [CAPACITY-1:0] tbl_busy;

  int   bad_fields;
  int   cmds_taken;
  int   quiet_cycles;
  logic cmd_taken;
  logic [TIME_W-1:0] stim_clock;  // notional "now" used to build sensible deadlines

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  task automatic note_mismatch(string msg);
    if (bad_fields < MAX_PRINTS) $display("[%0t] mismatch: %s", $realtime, msg);
    bad_fields++;
  endtask

  function automatic timer_result_t make_result(res_kind_t k, int slot, logic chg,
                                                logic dv, logic [TIME_W-1:0] nd, logic lst);
    timer_result_t r;
    r.kind             = k;
    r.handle           = HANDLE_W'(slot);
    r.earliest_changed = chg;
    r.deadline_valid   = dv;
    r.next_deadline    = nd;
    r.last             = lst;
    return r;
  endfunction

  // Earliest busy deadline; 0 and a low return when the table is empty.
  function automatic logic earliest_pending(output logic [TIME_W-1:0] when);
    logic any;
    any  = 1'b0;
    when = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (tbl_busy[i] && (!any || tbl_deadline[i] < when)) begin
        when = tbl_deadline[i];
        any  = 1'b1;
      end
    end
    return any;
  endfunction

  // Apply one accepted command to the shadow table and queue the results it owes.
  task automatic advance_timer_table(timer_cmd_t c);
    int                  slot;
    int                  pick;
    logic                any;
    logic                chg;
    logic [TIME_W-1:0]   best;
    logic [CAPACITY-1:0] due;
    logic [TIME_W:0]     reload;

    if (c.cmd == CMD_ADD) begin
      slot = -1;
      for (int i = CAPACITY - 1; i >= 0; i--) if (!tbl_busy[i]) slot = i;
      any = earliest_pending(best);
      if (slot < 0) begin
        // table full: rejected, next deadline unchanged
        awaited_results.push_back(make_result(KIND_ADD_FULL, 0, 1'b0, any, best, 1'b1));
      end else begin
        chg = !any || (c.time_value < best);  // strict: a tie is not a new earliest
        tbl_deadline[slot] = c.time_value;
        tbl_period[slot]   = c.interval_us;
        tbl_busy[slot]     = 1'b1;
        any = earliest_pending(best);
        awaited_results.push_back(make_result(KIND_ADD_OK, slot, chg, any, best, 1'b1));
      end
    end else begin
      // Due set is frozen at the start, so a reloaded timer cannot fire twice per pass.
      for (int i = 0; i < CAPACITY; i++)
        due[i] = tbl_busy[i] && (tbl_deadline[i] <= c.time_value);
      while (due != '0) begin
        pick = -1;
        for (int i = 0; i < CAPACITY; i++)
          if (due[i] && (pick < 0 || tbl_deadline[i] < tbl_deadline[pick])) pick = i;
        due[pick] = 1'b0;
        awaited_results.push_back(make_result(KIND_FIRED, pick, 1'b0, 1'b0, '0, 1'b0));
        if (tbl_period[pick] != '0) begin
          reload = {1'b0, c.time_value} + (TIME_W+1)'(tbl_period[pick]);
          tbl_deadline[pick] = reload[TIME_W] ? TIME_TOP : reload[TIME_W-1:0];
        end else begin
          tbl_busy[pick] = 1'b0;
        end
      end
      any = earliest_pending(best);
      awaited_results.push_back(make_result(KIND_PASS_DONE, 0, 1'b0, any, best, 1'b1));
    end
  endtask

  task automatic push_cmd(logic cmd, logic [TIME_W-1:0] t, logic [PERIOD_W-1:0] per);
    timer_cmd_t c;
    c.cmd         = cmd;
    c.time_value  = t;
    c.interval_us = per;
    cmd_backlog.push_back(c);
  endtask

  function automatic logic [TIME_W-1:0] any_time();
    return TIME_W'({$urandom(), $urandom()});
  endfunction

  // Ordinary traffic: mostly near-future one-shots, a few periodic timers, and expire
  // passes that walk the notional clock forward so each pass fires a handful.
  task automatic random_traffic(int n);
    logic [PERIOD_W-1:0] per;
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 99) < 60) begin
        per = '0;
        if ($urandom_range(0, 9) == 0)
          per = $urandom_range(0, 1) ? PERIOD_W'($urandom_range(1, 4000)) : $urandom();
        if ($urandom_range(0, 9) == 0)
          push_cmd(CMD_ADD, any_time(), per);
        else
          push_cmd(CMD_ADD, stim_clock + TIME_W'($urandom_range(0, 3000)), per);
      end else if ($urandom_range(0, 11) == 0) begin
        // off-clock pass, may reach far into the future
        push_cmd(CMD_EXPIRE, any_time(), $urandom());
      end else begin
        stim_clock = stim_clock + TIME_W'($urandom_range(0, 2500));
        push_cmd(CMD_EXPIRE, stim_clock, $urandom());
      end
    end
  endtask

  // Overfill the table so adds get rejected, then flush it with two passes; the pass
  // at the top of time fires every pending timer at once.
  task automatic fill_then_flush();
    for (int k = 0; k < CAPACITY + 4; k++)
      push_cmd(CMD_ADD, stim_clock + TIME_W'($urandom_range(0, 4000)),
               ($urandom_range(0, 15) == 0) ? PERIOD_W'($urandom_range(1, 900)) : '0);
    push_cmd(CMD_EXPIRE, stim_clock + TIME_W'(2000), $urandom());
    push_cmd(CMD_EXPIRE, TIME_TOP, $urandom());
    stim_clock = stim_clock + TIME_W'(4000);
  endtask

  // Driver: everything changes on the falling edge. A command stays on the bus until
  // the monitor has seen its transfer. Idling on both sides is switched off for a
  // window of commands in the middle of the run.
  always @(negedge clk) begin
    logic calm;
    calm = (cmds_taken >= 200) && (cmds_taken < 260);
    if (rst_n) begin
      if (!in_chan.valid || cmd_taken) begin
        if (cmd_backlog.size() != 0 && (calm || $urandom_range(0, 99) >= 29)) begin
          in_chan.valid       <= 1'b1;
          in_chan.cmd         <= cmd_backlog[0].cmd;
          in_chan.time_value  <= cmd_backlog[0].time_value;
          in_chan.interval_us <= cmd_backlog[0].interval_us;
          void'(cmd_backlog.pop_front());
        end else begin
          in_chan.valid <= 1'b0;
        end
      end
      out_chan.ready <= calm || ($urandom_range(0, 99) >= 29);
    end
  end

  // Monitor: samples both channels on the rising edge, predicts on each command
  // transfer and checks each result transfer against the oldest expectation.
  always @(posedge clk) begin
    timer_result_t want;
    logic moved;
    moved = 1'b0;
    if (rst_n) begin
      if (in_chan.valid && in_chan.ready) begin
        advance_timer_table({in_chan.cmd, in_chan.time_value, in_chan.interval_us});
        cmds_taken++;
        moved = 1'b1;
      end
      if (out_chan.valid && out_chan.ready) begin
        moved = 1'b1;
        if (awaited_results.size() == 0) begin
          note_mismatch($sformatf("result with none due: kind %0d handle %0d",
                                  out_chan.kind, out_chan.handle));
        end else begin
          want = awaited_results.pop_front();
          if (out_chan.kind !== want.kind)
            note_mismatch($sformatf("kind %0d, want %0d", out_chan.kind, want.kind));
          if (out_chan.handle !== want.handle)
            note_mismatch($sformatf("handle %0d, want %0d", out_chan.handle, want.handle));
          if (out_chan.earliest_changed !== want.earliest_changed)
            note_mismatch($sformatf("earliest_changed %b, want %b",
                                    out_chan.earliest_changed, want.earliest_changed));
          if (out_chan.deadline_valid !== want.deadline_valid)
            note_mismatch($sformatf("deadline_valid %b, want %b",
                                    out_chan.deadline_valid, want.deadline_valid));
          if (out_chan.next_deadline !== want.next_deadline)
            note_mismatch($sformatf("next_deadline %h, want %h",
                                    out_chan.next_deadline, want.next_deadline));
          if (out_chan.last !== want.last)
            note_mismatch($sformatf("last %b, want %b", out_chan.last, want.last));
        end
      end
    end
    cmd_taken <= rst_n && in_chan.valid && in_chan.ready;

    // Watchdog: only counts while something is still owed.
    if (!moved && rst_n &&
        (cmd_backlog.size() != 0 || awaited_results.size() != 0 || in_chan.valid))
      quiet_cycles++;
    else
      quiet_cycles = 0;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    rst_n               = 1'b0;
    in_chan.valid       = 1'b0;
    in_chan.cmd         = CMD_ADD;
    in_chan.time_value  = '0;
    in_chan.interval_us = '0;
    out_chan.ready      = 1'b0;
    cmd_taken           = 1'b0;
    bad_fields          = 0;
    cmds_taken          = 0;
    quiet_cycles        = 0;
    tbl_busy            = '0;
    stim_clock          = TIME_W'(1000);

    // Directed opening.
    push_cmd(CMD_ADD, TIME_W'(5000), '0);          // empty table: becomes earliest
    push_cmd(CMD_ADD, TIME_W'(6000), '0);          // later deadline
    push_cmd(CMD_ADD, TIME_W'(5000), '0);          // tie with earliest: not strictly earlier
    push_cmd(CMD_ADD, TIME_W'(4000), PERIOD_W'(250));  // periodic, new earliest
    push_cmd(CMD_EXPIRE, TIME_W'(100), PERIOD_TOP);    // nothing due: pass-done only
    push_cmd(CMD_ADD, '0, '0);                     // deadline zero
    push_cmd(CMD_EXPIRE, TIME_W'(5000), $urandom());   // ordered fire, tie broken by slot
    push_cmd(CMD_EXPIRE, TIME_W'(5250), '0);       // periodic comes round again
    push_cmd(CMD_ADD, TIME_TOP, PERIOD_TOP);       // extremes of both fields
    push_cmd(CMD_ADD, TIME_TOP - TIME_W'(15), PERIOD_W'(5));
    push_cmd(CMD_EXPIRE, TIME_TOP, PERIOD_TOP);    // reloads saturate, no second fire
    push_cmd(CMD_EXPIRE, TIME_TOP, '0);            // saturated timers fire again
    push_cmd(CMD_EXPIRE, '0, '0);
    stim_clock = TIME_W'(7000);

    random_traffic(100);
    fill_then_flush();
    random_traffic(150);
    fill_then_flush();

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (cmd_backlog.size() != 0 || in_chan.valid || awaited_results.size() != 0)
      @(negedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (awaited_results.size() != 0)
      note_mismatch($sformatf("%0d results never arrived", awaited_results.size()));
    if (bad_fields == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
